[rtl/amx_pkg.sv]
package amx_pkg;

   localparam int MODE_W     = 2;
   localparam int VERTEX_W   = 5;
   localparam int NEIGHBOR_W = 5;
   localparam int CSR_W      = 6;
   localparam int CNT_W      = 6;
   localparam int CMP_W      = 8;
   localparam int MAX_RESULTS = 32;

   localparam logic [CSR_W-1:0] VCOUNT_RESET = 6'd32;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD  = 2'd0,
      MODE_SUCC = 2'd1,
      MODE_PRED = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ADD  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_LAST = 4'b1000
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

[rtl/amx_if.sv]
interface amx_req_if;
   logic                          valid;
   logic                          ready;
   logic [amx_pkg::MODE_W-1:0]    mode;
   logic [amx_pkg::VERTEX_W-1:0]  first_vertex;
   logic [amx_pkg::VERTEX_W-1:0]  second_vertex;

   modport source (output valid, output mode, output first_vertex, output second_vertex,
                   input ready);
   modport sink   (input valid, input mode, input first_vertex, input second_vertex,
                   output ready);
endinterface

interface amx_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [amx_pkg::NEIGHBOR_W-1:0] neighbor;
   logic                           has_neighbor;
   logic                           error;
   logic                           last;

   modport source (output valid, output neighbor, output has_neighbor, output error,
                   output last, input ready);
   modport sink   (input valid, input neighbor, input has_neighbor, input error,
                   input last, output ready);
endinterface

[rtl/amx_mem.sv]
module amx_mem #(
   parameter int MAX_VERTICES = 32,
   parameter int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
   input  logic                    clock,
   input  logic                    clear,
   input  amx_pkg::mem_ctl_type    ctl,
   input  logic [VW-1:0]           rd_addr,
   input  logic [VW-1:0]           wr_addr,
   input  logic [MAX_VERTICES-1:0] wr_data,
   output logic [MAX_VERTICES-1:0] rd_data
);

   logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_vld_ff;
   logic [MAX_VERTICES-1:0] rd_data_ff;

   // A row never written since the last clear reads as all zero.
   always_ff @(posedge clock) begin
      if (clear) begin
         row_vld_ff <= '0;
      end else if (ctl.wr_en) begin
         row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         rows[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= row_vld_ff[rd_addr] ? rows[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/amx_seq.sv]
module amx_seq #(
   parameter int MAX_VERTICES = 32,
   parameter int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
   parameter int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CW-1:0]           vcount,
   amx_req_if.sink                 req,
   amx_rsp_if.source               rsp,
   output amx_pkg::mem_ctl_type    mem_ctl,
   output logic [VW-1:0]           rd_addr,
   output logic [VW-1:0]           wr_addr,
   output logic [MAX_VERTICES-1:0] wr_data,
   input  logic [MAX_VERTICES-1:0] rd_data
);

   amx_pkg::state_type state_ff, state_in;
   amx_pkg::mode_type  mode_ff, mode_in;
   logic [VW-1:0]              a_row_ff, a_row_in;
   logic [VW-1:0]              b_row_ff, b_row_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [amx_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VW-1:0]              pend_ff, pend_in;
   logic                       err_ff, err_in;

   logic                           rsp_vld_ff;
   logic [amx_pkg::NEIGHBOR_W-1:0] nb_ff, nb_in;
   logic                           has_ff, has_in;
   logic                           rerr_ff, rerr_in;
   logic                           last_ff, last_in;

   logic          accept, out_free, push;
   logic          a_ok, b_ok, hit, done;
   logic [VW-1:0] req_a_row, req_b_row;

   assign req.ready = (state_ff == amx_pkg::ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_vld_ff || rsp.ready;

   assign a_ok = amx_pkg::CMP_W'(req.first_vertex)  < amx_pkg::CMP_W'(vcount);
   assign b_ok = amx_pkg::CMP_W'(req.second_vertex) < amx_pkg::CMP_W'(vcount);
   assign req_a_row = VW'({{VW{1'b0}}, req.first_vertex});
   assign req_b_row = VW'({{VW{1'b0}}, req.second_vertex});

   // Successors test bit idx of the held row; predecessors test column a of row idx.
   assign hit  = (mode_ff == amx_pkg::MODE_SUCC) ? rd_data[idx_ff[VW-1:0]] : rd_data[a_row_ff];
   assign done = (idx_ff >= vcount) ||
                 (amx_pkg::CMP_W'(cnt_ff) == amx_pkg::CMP_W'(amx_pkg::MAX_RESULTS));

   assign wr_addr = a_row_ff;
   assign wr_data = rd_data | (MAX_VERTICES'(1) << b_row_ff);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      a_row_in = a_row_ff;
      b_row_in = b_row_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      err_in   = err_ff;
      mem_ctl  = '0;
      rd_addr  = '0;
      push     = 1'b0;
      nb_in    = '0;
      has_in   = 1'b0;
      rerr_in  = 1'b0;
      last_in  = 1'b0;

      case (state_ff)
         amx_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in  = amx_pkg::mode_type'(req.mode);
               a_row_in = req_a_row;
               b_row_in = req_b_row;
               idx_in   = '0;
               cnt_in   = '0;
               err_in   = 1'b1;
               state_in = amx_pkg::ST_LAST;
               case (amx_pkg::mode_type'(req.mode))
                  amx_pkg::MODE_ADD: begin
                     if (a_ok && b_ok) begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = req_a_row;
                        err_in        = 1'b0;
                        state_in      = amx_pkg::ST_ADD;
                     end
                  end
                  amx_pkg::MODE_SUCC: begin
                     if (a_ok) begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = req_a_row;
                        err_in        = 1'b0;
                        state_in      = amx_pkg::ST_SCAN;
                     end
                  end
                  amx_pkg::MODE_PRED: begin
                     if (a_ok) begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = '0;
                        err_in        = 1'b0;
                        state_in      = amx_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     err_in = 1'b1;
                  end
               endcase
            end
         end
         amx_pkg::ST_ADD: begin
            mem_ctl.wr_en = 1'b1;
            state_in      = amx_pkg::ST_LAST;
         end
         amx_pkg::ST_SCAN: begin
            if (done) begin
               state_in = amx_pkg::ST_LAST;
            end else if (!(hit && (cnt_ff != '0) && !out_free)) begin
               // A new hit releases the one held back, which is then known not to be last.
               if (hit) begin
                  if (cnt_ff != '0) begin
                     push  = 1'b1;
                     nb_in = amx_pkg::NEIGHBOR_W'({{amx_pkg::NEIGHBOR_W{1'b0}}, pend_ff});
                     has_in = 1'b1;
                  end
                  pend_in = idx_ff[VW-1:0];
                  cnt_in  = cnt_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
               if ((mode_ff == amx_pkg::MODE_PRED) && (idx_ff != CW'(MAX_VERTICES - 1))) begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = VW'(idx_ff + 1'b1);
               end
            end
         end
         amx_pkg::ST_LAST: begin
            if (out_free) begin
               push     = 1'b1;
               has_in   = (cnt_ff != '0);
               nb_in    = (cnt_ff != '0) ?
                          amx_pkg::NEIGHBOR_W'({{amx_pkg::NEIGHBOR_W{1'b0}}, pend_ff}) : '0;
               rerr_in  = err_ff;
               last_in  = 1'b1;
               state_in = amx_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = amx_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= amx_pkg::ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (push) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      a_row_ff <= a_row_in;
      b_row_ff <= b_row_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      pend_ff  <= pend_in;
      err_ff   <= err_in;
      if (push) begin
         nb_ff   <= nb_in;
         has_ff  <= has_in;
         rerr_ff <= rerr_in;
         last_ff <= last_in;
      end
   end

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.neighbor     = nb_ff;
   assign rsp.has_neighbor = has_ff;
   assign rsp.error        = rerr_ff;
   assign rsp.last         = last_ff;

endmodule

[rtl/adjacency_matrix_store.sv]
// Channel   Role    Handshake      Content
// req       sink    valid/ready    mode, first_vertex, second_vertex
// rsp       source  valid/ready    neighbor, has_neighbor, error, last
// csr       write   csr_wr_en      vertex_count, no read-back
//
// A listing's scan tests one matrix bit per cycle from one read port, unless a stalled rsp
// holds it. Synchronous reset and every vertex_count write clear the matrix through per-row
// valid bits. A stalled rsp holds the scan only when a further neighbor is found while
// one is held back, and it holds the final result; req is ready only between requests.
module adjacency_matrix_store #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   amx_req_if.sink                    req,
   amx_rsp_if.source                  rsp,
   input  logic                       csr_wr_en,
   input  logic [amx_pkg::CSR_W-1:0]  csr_wr_data
);

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   logic [amx_pkg::CSR_W-1:0] vcount_ff;
   logic [CW-1:0]             vcount_eff;
   amx_pkg::mem_ctl_type      mem_ctl;
   logic [VW-1:0]             rd_addr, wr_addr;
   logic [MAX_VERTICES-1:0]   wr_data, rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= amx_pkg::VCOUNT_RESET;
      end else if (csr_wr_en) begin
         vcount_ff <= csr_wr_data;
      end
   end

   assign vcount_eff = (amx_pkg::CMP_W'(vcount_ff) > amx_pkg::CMP_W'(MAX_VERTICES)) ?
                       CW'(MAX_VERTICES) : CW'(vcount_ff);

   amx_mem #(.MAX_VERTICES(MAX_VERTICES), .VW(VW)) u_mem (
      .clock   (clock),
      .clear   (reset || csr_wr_en),
      .ctl     (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   amx_seq #(.MAX_VERTICES(MAX_VERTICES), .VW(VW), .CW(CW)) u_seq (
      .clock   (clock),
      .reset   (reset),
      .vcount  (vcount_eff),
      .req     (req),
      .rsp     (rsp),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted while previous one still in progress");

   a_error_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.error |-> rsp.last && !rsp.has_neighbor)
      else $error("error result not final or carries a neighbor");

   a_empty_neighbor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.has_neighbor |-> rsp.neighbor == '0 && rsp.last)
      else $error("result without neighbor is malformed");

   a_list_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.last |-> !req.ready)
      else $error("ready while a listing is still being delivered");

endmodule
